// ===== design/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by websocket_frame_deframer.
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HEAD0   = 3'd0,
    PH_HEAD1   = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_PARKED  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_PING  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_LONG  = 2'd3
  } kind_t;

  localparam logic [3:0]  OP_CLOSE       = 4'h8;
  localparam logic [3:0]  OP_PING        = 4'h9;
  localparam logic [3:0]  OP_PONG        = 4'hA;
  localparam logic [6:0]  LEN_CODE_16    = 7'd126;
  localparam logic [6:0]  LEN_CODE_64    = 7'd127;
  localparam logic [2:0]  EXT_BYTES_16   = 3'd1;
  localparam logic [2:0]  EXT_BYTES_64   = 3'd7;
  localparam logic [2:0]  KEY_COUNT_INIT = 3'd3;
  localparam logic [31:0] MAX_LEN_RESET  = 32'h1000_0000;

endpackage

// ===== design/websocket_frame_deframer.sv =====
// WebSocket frame deframer: header parse, length check, payload unmask.
// Depends on wsd_pkg (phase and kind codes, opcodes, length codes).
//
// Usage:
//   Input channel (in_valid/in_ready/in_byte) takes one received stream byte
//   per word. Output channel (out_valid/out_ready and the result fields)
//   gives at most one result per input byte: an unmasked payload byte, an
//   end-of-message marker, a close event or a length-over-limit event.
//   Configuration channel (cfg_valid/cfg_ready/cfg_data) writes the payload
//   length limit; it is always ready.
//   A result is registered and appears on the output in the cycle after
//   its byte is accepted. Bytes go through at one per cycle while results
//   are taken, set by the single header/unmask stage before the output register.
//   The output register parts the two sides: a new byte is taken while the
//   held result is being taken in the same cycle. If the receiver stalls with
//   a result held, in_ready drops and the byte stream holds.
//   Reset clears the parser to the first header byte and loads the limit
//   with 256 MiB. After a close frame or an oversize length the block parks:
//   it keeps taking bytes but drops them, until the next reset.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  kind,
  output logic        has_byte,
  output logic        ends_message,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  // Parser state
  phase_t      phase, phase_next;
  logic [2:0]  field_byte_count, field_byte_count_next;
  logic        final_flag, final_flag_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        masked_flag, masked_flag_next;
  logic [63:0] remaining_length, remaining_length_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_index, mask_index_next;
  logic [31:0] max_payload_length;

  // Result of the current byte, before the output register
  logic        res_emit;
  kind_t       res_kind;
  logic [7:0]  res_byte;
  logic        res_has;
  logic        res_ends;

  logic        in_fire;
  logic [6:0]  len7;
  logic        len_done;
  logic [63:0] len_value;
  logic        over_limit;
  logic        masked_eff;
  logic        start_now;
  logic [63:0] start_len;
  logic        start_empty;
  logic [7:0]  key_byte;
  logic [7:0]  plain_byte;
  logic        last_byte;

  // Empty-frame result, shared by the end of the header and the end of the mask
  logic        empty_emit;
  kind_t       empty_kind;
  logic        empty_ends;
  logic        empty_park;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign len7 = in_byte[6:0];

  // Length is complete at the second header byte for short lengths, or at
  // the last extended-length byte.
  always_comb begin
    len_done  = 1'b0;
    len_value = {remaining_length[55:0], in_byte};
    if (phase == PH_HEAD1) begin
      len_done  = (len7 != LEN_CODE_16) && (len7 != LEN_CODE_64);
      len_value = {57'd0, len7};
    end else if (phase == PH_EXT) begin
      len_done  = (field_byte_count == 3'd0);
    end
  end

  assign over_limit = (|len_value[63:32]) || (len_value[31:0] > max_payload_length);
  assign masked_eff = (phase == PH_HEAD1) ? in_byte[7] : masked_flag;

  // Payload starts after the length (unmasked) or after the last key byte
  always_comb begin
    start_now = 1'b0;
    start_len = len_value;
    if (len_done && !over_limit && !masked_eff) begin
      start_now = 1'b1;
    end else if (phase == PH_MASK && field_byte_count == 3'd0) begin
      start_now = 1'b1;
      start_len = remaining_length;
    end
  end

  assign start_empty = (start_len == 64'd0);

  always_comb begin
    empty_emit = 1'b0;
    empty_kind = KIND_DATA;
    empty_ends = 1'b0;
    empty_park = 1'b0;
    if (frame_opcode == OP_CLOSE) begin
      empty_emit = 1'b1;
      empty_kind = KIND_CLOSE;
      empty_park = 1'b1;
    end else if (frame_opcode == OP_PING) begin
      empty_emit = 1'b1;
      empty_kind = KIND_PING;
      empty_ends = 1'b1;
    end else if (frame_opcode != OP_PONG && final_flag) begin
      empty_emit = 1'b1;
      empty_ends = 1'b1;
    end
  end

  // Unmask with key byte (index mod 4), first received key byte first
  always_comb begin
    case (mask_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  assign plain_byte = masked_flag ? (in_byte ^ key_byte) : in_byte;
  assign last_byte  = (remaining_length == 64'd1);

  // Next-state logic
  always_comb begin
    phase_next            = phase;
    field_byte_count_next = field_byte_count;
    final_flag_next       = final_flag;
    frame_opcode_next     = frame_opcode;
    masked_flag_next      = masked_flag;
    remaining_length_next = remaining_length;
    mask_key_next         = mask_key;
    mask_index_next       = mask_index;

    case (phase)
      PH_HEAD0: begin
        final_flag_next   = in_byte[7];
        frame_opcode_next = in_byte[3:0];
        phase_next        = PH_HEAD1;
      end
      PH_HEAD1, PH_EXT: begin
        if (phase == PH_HEAD1) begin
          masked_flag_next      = in_byte[7];
          mask_key_next         = 32'd0;
          remaining_length_next = 64'd0;
          if (len7 == LEN_CODE_16) begin
            field_byte_count_next = EXT_BYTES_16;
            phase_next            = PH_EXT;
          end else if (len7 == LEN_CODE_64) begin
            field_byte_count_next = EXT_BYTES_64;
            phase_next            = PH_EXT;
          end
        end else if (!len_done) begin
          remaining_length_next = len_value;
          field_byte_count_next = field_byte_count - 3'd1;
        end
        if (len_done) begin
          remaining_length_next = len_value;
          if (over_limit) begin
            phase_next = PH_PARKED;
          end else if (masked_eff) begin
            phase_next            = PH_MASK;
            field_byte_count_next = KEY_COUNT_INIT;
          end
        end
      end
      PH_MASK: begin
        mask_key_next = {mask_key[23:0], in_byte};
        if (field_byte_count != 3'd0) begin
          field_byte_count_next = field_byte_count - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        mask_index_next       = mask_index + 2'd1;
        remaining_length_next = remaining_length - 64'd1;
        if (last_byte) begin
          phase_next = (frame_opcode == OP_CLOSE) ? PH_PARKED : PH_HEAD0;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase

    if (start_now) begin
      mask_index_next = 2'd0;
      if (!start_empty) begin
        phase_next = PH_PAYLOAD;
      end else begin
        phase_next = empty_park ? PH_PARKED : PH_HEAD0;
      end
    end
  end

  // Result logic
  always_comb begin
    res_emit = 1'b0;
    res_kind = KIND_DATA;
    res_byte = 8'd0;
    res_has  = 1'b0;
    res_ends = 1'b0;
    case (phase)
      PH_HEAD1, PH_EXT, PH_MASK: begin
        if (len_done && over_limit) begin
          res_emit = 1'b1;
          res_kind = KIND_LONG;
        end else if (start_now && start_empty) begin
          res_emit = empty_emit;
          res_kind = empty_kind;
          res_ends = empty_ends;
        end
      end
      PH_PAYLOAD: begin
        if (frame_opcode == OP_CLOSE) begin
          res_emit = last_byte;
          res_kind = KIND_CLOSE;
        end else if (frame_opcode == OP_PING) begin
          res_emit = 1'b1;
          res_kind = KIND_PING;
          res_byte = plain_byte;
          res_has  = 1'b1;
          res_ends = last_byte;
        end else if (frame_opcode != OP_PONG) begin
          res_emit = 1'b1;
          res_byte = plain_byte;
          res_has  = 1'b1;
          res_ends = last_byte && final_flag;
        end
      end
      default: begin
        res_emit = 1'b0;
      end
    endcase
  end

  // State registers: advance only on an accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEAD0;
      field_byte_count <= 3'd0;
      final_flag       <= 1'b0;
      frame_opcode     <= 4'd0;
      masked_flag      <= 1'b0;
      remaining_length <= 64'd0;
      mask_key         <= 32'd0;
      mask_index       <= 2'd0;
    end else if (in_fire) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      final_flag       <= final_flag_next;
      frame_opcode     <= frame_opcode_next;
      masked_flag      <= masked_flag_next;
      remaining_length <= remaining_length_next;
      mask_key         <= mask_key_next;
      mask_index       <= mask_index_next;
    end
  end

  // Length limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_length <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_length <= cfg_data;
    end
  end

  // Output register: load a new result, else drop the taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && res_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_emit) begin
      out_byte     <= res_byte;
      kind         <= res_kind;
      has_byte     <= res_has;
      ends_message <= res_ends;
    end
  end

  // Checks
  a_parked_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PARKED) |-> !res_emit)
    else $error("result produced while parked");

  a_event_parks: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_emit && (res_kind == KIND_CLOSE || res_kind == KIND_LONG))
      |=> (phase == PH_PARKED))
    else $error("close or length event did not park the parser");

  a_payload_nonempty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (remaining_length != 64'd0))
    else $error("payload phase with no bytes remaining");

  a_byte_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && has_byte) |-> (kind == KIND_DATA || kind == KIND_PING))
    else $error("payload byte carried by an event result");

endmodule

// ===== tb/websocket_frame_deframer_test.sv =====
// Self-checking testbench for websocket_frame_deframer: frame streams with random
// pacing on both channels, checked word by word against a built-in frame predictor.
// Depends on wsd_pkg for the phase and kind codes, opcodes and length codes.
module websocket_frame_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PRINT_CAP    = 50;

  // Opcodes that the package does not name.
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_RESV_F = 4'hF;

  // Three ways to encode a payload length on the wire.
  typedef enum int {FORM_7, FORM_16, FORM_64} len_form_t;

  // Pacing modes of the receiving side.
  typedef enum int {RX_STEADY, RX_RANDOM, RX_RUNS} rx_mode_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       has;
    logic       ends;
  } ws_word_t;

  // Tracks the frame parser state byte by byte and holds the words it owes.
  class deframer_tracker;
    logic [31:0] limit;
    phase_t      phase;
    logic [2:0]  field_left;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] remaining;
    logic [31:0] key;
    logic [1:0]  key_pos;
    ws_word_t    words_due[$];
    int unsigned kind_seen[4];
    int unsigned checked;

    function new();
      limit      = MAX_LEN_RESET;
      phase      = PH_HEAD0;
      field_left = '0;
      fin        = 1'b0;
      opcode     = '0;
      masked     = 1'b0;
      remaining  = '0;
      key        = '0;
      key_pos    = '0;
      checked    = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void queue_word(logic [7:0] data, kind_t k, logic has, logic ends);
      ws_word_t w;
      w.data = data;
      w.kind = k;
      w.has  = has;
      w.ends = ends;
      words_due.insert(words_due.size(), w);
      kind_seen[k]++;
    endfunction

    function void open_payload();
      key_pos = '0;
      if (remaining != 64'd0) begin
        phase = PH_PAYLOAD;
      end else begin
        phase = PH_HEAD0;
        if (opcode == OP_CLOSE) begin
          phase = PH_PARKED;
          queue_word(8'h00, KIND_CLOSE, 1'b0, 1'b0);
        end else if (opcode == OP_PING) begin
          queue_word(8'h00, KIND_PING, 1'b0, 1'b1);
        end else if (opcode != OP_PONG && fin) begin
          queue_word(8'h00, KIND_DATA, 1'b0, 1'b1);
        end
      end
    endfunction

    function void length_known();
      if (remaining > {32'd0, limit}) begin
        phase = PH_PARKED;
        queue_word(8'h00, KIND_LONG, 1'b0, 1'b0);
      end else if (masked) begin
        phase      = PH_MASK;
        field_left = KEY_COUNT_INIT;
      end else begin
        open_payload();
      end
    endfunction

    function void payload_byte(logic [7:0] raw);
      logic [7:0] plain;
      logic       last;
      plain     = masked ? (raw ^ key[8*(3 - key_pos) +: 8]) : raw;
      key_pos   = key_pos + 2'd1;
      remaining = remaining - 64'd1;
      last      = (remaining == 64'd0);
      if (last) phase = PH_HEAD0;
      if (opcode == OP_CLOSE) begin
        if (last) begin
          phase = PH_PARKED;
          queue_word(8'h00, KIND_CLOSE, 1'b0, 1'b0);
        end
      end else if (opcode == OP_PING) begin
        queue_word(plain, KIND_PING, 1'b1, last);
      end else if (opcode != OP_PONG) begin
        queue_word(plain, KIND_DATA, 1'b1, last & fin);
      end
    endfunction

    // Note one accepted stream byte.
    function void note_byte(logic [7:0] b);
      case (phase)
        PH_HEAD0: begin
          fin    = b[7];
          opcode = b[3:0];
          phase  = PH_HEAD1;
        end
        PH_HEAD1: begin
          masked    = b[7];
          key       = '0;
          remaining = '0;
          if (b[6:0] == LEN_CODE_16) begin
            field_left = EXT_BYTES_16;
            phase      = PH_EXT;
          end else if (b[6:0] == LEN_CODE_64) begin
            field_left = EXT_BYTES_64;
            phase      = PH_EXT;
          end else begin
            remaining = {57'd0, b[6:0]};
            length_known();
          end
        end
        PH_EXT: begin
          remaining = {remaining[55:0], b};
          if (field_left == 3'd0) length_known();
          else field_left = field_left - 3'd1;
        end
        PH_MASK: begin
          key = {key[23:0], b};
          if (field_left == 3'd0) open_payload();
          else field_left = field_left - 3'd1;
        end
        PH_PAYLOAD: payload_byte(b);
        default: ;
      endcase
    endfunction

    // Check one accepted result word; return a description of what is wrong.
    function string check_word(logic [7:0] data, logic [1:0] k, logic has, logic ends);
      ws_word_t want;
      string    why;
      why = "";
      if (words_due.size() == 0) begin
        why = $sformatf(" nothing due, got out_byte=%02h kind=%0d has_byte=%0b ends_message=%0b",
                        data, k, has, ends);
      end else begin
        want = words_due.pop_front();
        checked++;
        if (data !== want.data)
          why = {why, $sformatf(" out_byte=%02h want %02h", data, want.data)};
        if (k !== want.kind)
          why = {why, $sformatf(" kind=%0d want %0d", k, want.kind)};
        if (has !== want.has)
          why = {why, $sformatf(" has_byte=%0b want %0b", has, want.has)};
        if (ends !== want.ends)
          why = {why, $sformatf(" ends_message=%0b want %0b", ends, want.ends)};
      end
      return why;
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte      = 8'h00;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic        has_byte;
  logic        ends_message;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data     = 32'd0;

  deframer_tracker tracker = new();

  int unsigned cycle_count = 0;
  int unsigned bytes_taken = 0;
  int unsigned fail_count  = 0;
  int unsigned burst_left  = 0;
  bit          gaps_on     = 1'b0;
  int unsigned mode_left   = 0;
  int unsigned stall_run   = 0;
  rx_mode_t    stall_mode  = RX_STEADY;

  websocket_frame_deframer u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .kind         (kind),
    .has_byte     (has_byte),
    .ends_message (ends_message),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= PRINT_CAP) $display("MISMATCH cycle %0d:%s", cycle_count, msg);
  endtask

  // Watch all three handshakes at each edge. Check the output word before
  // noting the input byte so a stray word can never match a fresh expectation.
  always @(posedge clk) begin : handshake_watch
    string why;
    if (!rst) begin
      if (out_valid && out_ready) begin
        why = tracker.check_word(out_byte, kind, has_byte, ends_message);
        if (why != "") report(why);
      end
      if (in_valid && in_ready) begin
        tracker.note_byte(in_byte);
        bytes_taken++;
      end
      if (cfg_valid && cfg_ready) tracker.limit = cfg_data;
    end
  end

  // Receiver pacing: switch at random between steady, random and run-length
  // stalls.
  always @(posedge clk) begin : rx_pacing
    if (mode_left == 0) begin
      mode_left  = $urandom_range(30, 200);
      stall_mode = rx_mode_t'($urandom_range(0, 2));
    end
    mode_left--;
    case (stall_mode)
      RX_STEADY: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
      default: begin
        if (stall_run > 0) begin
          out_ready <= 1'b0;
          stall_run--;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 4) == 0) stall_run = $urandom_range(1, 8);
        end
      end
    endcase
  end

  // Offer one stream byte and hold it until taken. Open a gap between bursts
  // when pacing is on; keep valid high across back-to-back bytes.
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap        = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Send the two header bytes, the extended length in the chosen form and,
  // when masked, a fresh random key.
  task automatic send_header(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                             input logic masked, input logic [63:0] len,
                             input len_form_t form);
    logic [31:0] key;
    key = $urandom;
    push_byte({fin, rsv, op});
    case (form)
      FORM_7: push_byte({masked, len[6:0]});
      FORM_16: begin
        push_byte({masked, LEN_CODE_16});
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
      default: begin
        push_byte({masked, LEN_CODE_64});
        for (int i = 7; i >= 0; i--) push_byte(len[8*i +: 8]);
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) push_byte(key[8*i +: 8]);
  endtask

  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                            input logic masked, input logic [63:0] len,
                            input len_form_t form);
    longint unsigned n;
    send_header(fin, rsv, op, masked, len, form);
    for (n = 0; n < len; n++) push_byte(8'($urandom_range(0, 255)));
  endtask

  // Drop valid, wait for every owed word, then let the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the limit and drop the request again; the tracker then holds the new value.
  task automatic write_limit(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stream well-formed frames with random headers and payloads, never a close
  // and never over the current limit, until the byte goal is met.
  task automatic stream_frames(input int unsigned byte_goal);
    int unsigned stop_at;
    int unsigned cap;
    logic        fin;
    logic [2:0]  rsv;
    logic [3:0]  op;
    logic        masked;
    logic [63:0] len;
    len_form_t   form;
    stop_at = bytes_taken + byte_goal;
    cap     = (tracker.limit < 300) ? tracker.limit : 300;
    while (bytes_taken < stop_at) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      fin     = ($urandom_range(0, 2) != 0);
      rsv     = 3'($urandom_range(0, 7));
      masked  = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: op = 4'($urandom_range(OP_CONT, OP_BINARY));
        4, 5:       op = OP_PING;
        6:          op = OP_PONG;
        default:    do op = 4'($urandom_range(0, 15)); while (op == OP_CLOSE);
      endcase
      if ($urandom_range(0, 9) == 0) len = 64'($urandom_range(0, cap));
      else len = 64'($urandom_range(0, (cap < 16) ? cap : 16));
      if (len > 125) begin
        form = ($urandom_range(0, 1) != 0) ? FORM_64 : FORM_16;
      end else begin
        case ($urandom_range(0, 5))
          0:       form = FORM_16;
          1:       form = FORM_64;
          default: form = FORM_7;
        endcase
      end
      send_frame(fin, rsv, op, masked, len, form);
    end
    settle();
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("TIMEOUT after %0d cycles, %0d words still due", cycle_count,
             tracker.words_due.size());
    $display("websocket_frame_deframer verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] small_limit;
    logic [31:0] park_limit;
    logic [63:0] len;
    logic [2:0]  rsv;
    logic        masked;
    len_form_t   form;
    bit          park_by_close;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset limit.
    gaps_on = ($urandom_range(0, 1) != 0);
    // Empty final continuation: a bare end-of-message word.
    send_frame(1'b1, 3'b000, OP_CONT, 1'b0, 64'd0, FORM_7);
    // Empty non-final text: silent.
    send_frame(1'b0, 3'b000, OP_TEXT, 1'b0, 64'd0, FORM_7);
    // Empty ping: a bare ping end word.
    send_frame(1'b1, 3'b000, OP_PING, 1'b0, 64'd0, FORM_7);
    // Pong payload: dropped.
    send_frame(1'b1, 3'b000, OP_PONG, 1'b0, 64'd1, FORM_7);
    // Masked ping with all RSV bits set: unmask and echo.
    send_frame(1'b1, 3'b111, OP_PING, 1'b1, 64'd2, FORM_7);
    // Binary fragment through the 16-bit length form.
    send_frame(1'b0, 3'b000, OP_BINARY, 1'b0, 64'd1, FORM_16);
    // Reserved opcode handled as data; header byte is all ones.
    send_frame(1'b1, 3'b111, OP_RESV_F, 1'b0, 64'd1, FORM_7);
    settle();

    // Random frames across several limit settings, extremes included.
    stream_frames(130);
    write_limit(32'hFFFF_FFFF);
    stream_frames(130);
    write_limit(32'd0);
    stream_frames(50);
    small_limit = $urandom_range(1, 12);
    write_limit(small_limit);
    stream_frames(120);
    park_limit = $urandom_range(13, 200);
    write_limit(park_limit);
    stream_frames(100);

    // Park the block, by a close frame or by an oversize length.
    gaps_on       = ($urandom_range(0, 1) != 0);
    park_by_close = ($urandom_range(0, 1) != 0);
    rsv           = 3'($urandom_range(0, 7));
    masked        = ($urandom_range(0, 1) != 0);
    if (park_by_close) begin
      form = len_form_t'($urandom_range(0, 2));
      send_frame(1'($urandom_range(0, 1)), rsv, OP_CLOSE, masked,
                 64'($urandom_range(0, 6)), form);
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          if (park_limit < 125) begin
            form = FORM_7;
            len  = 64'($urandom_range(park_limit + 1, 125));
          end else begin
            form = FORM_16;
            len  = 64'(park_limit) + 64'd1;
          end
        end
        1: begin
          form = FORM_16;
          len  = ($urandom_range(0, 1) != 0) ? 64'(park_limit) + 64'd1
                                               : 64'($urandom_range(park_limit + 1, 65535));
        end
        default: begin
          form = FORM_64;
          len  = {$urandom, $urandom};
          if (len <= {32'd0, park_limit}) len = 64'(park_limit) + 64'd1;
        end
      endcase
      // Any mask key after an oversize length is ignored; send it anyway.
      send_header(1'($urandom_range(0, 1)), rsv, OP_BINARY, masked, len, form);
    end

    // Parked: bytes are swallowed and a limit write changes nothing visible.
    repeat (20) push_byte(8'($urandom_range(0, 255)));
    settle();
    write_limit($urandom);
    settle();

    $display("Streamed %0d bytes under limits reset/max/zero/%0d/%0d, parked by %s.",
             bytes_taken, small_limit, park_limit, park_by_close ? "close" : "oversize length");
    $display("Checked %0d words: %0d data, %0d ping, %0d close, %0d over-limit.",
             tracker.checked, tracker.kind_seen[KIND_DATA], tracker.kind_seen[KIND_PING],
             tracker.kind_seen[KIND_CLOSE], tracker.kind_seen[KIND_LONG]);
    if (fail_count == 0 && tracker.words_due.size() == 0) begin
      $display("websocket_frame_deframer verification clean");
    end else begin
      $display("websocket_frame_deframer verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/wsd_pkg.sv
design/websocket_frame_deframer.sv
tb/websocket_frame_deframer_test.sv
